>>> hdl/kpc_pkg.sv
// kpc_pkg: shared types, codes and defaults for the key press classifier
// no dependencies; imported by the interfaces, kpc_update and the top level
`timescale 1ns / 1ps
`default_nettype none

package kpc_pkg;

  localparam int NUM_KEYS_DEF = 128;
  localparam int KEY_W        = 7;
  localparam int CNT_W        = 16;
  localparam int MASK_W       = 8;
  localparam int KIND_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CNT_W-1:0]  CNT_MAX         = 16'hFFFF;
  localparam logic              LISTEN_DEF      = 1'b1;
  localparam logic [CNT_W-1:0]  LONG_FRAMES_DEF = 16'd12;
  localparam logic [MASK_W-1:0] REPEAT_MASK_DEF = 8'h03;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LISTEN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MASK = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_FRAME = 2'd0,
    KIND_BLOCK = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_CLICK    = 3'd1,
    ST_SHORT    = 3'd2,
    ST_LONG     = 3'd3,
    ST_REPEAT   = 3'd4,
    ST_BLOCKED  = 3'd5,
    ST_RELEASED = 3'd6
  } status_t;

  // one table entry per key
  typedef struct packed {
    logic [CNT_W-1:0] hold_count;
    status_t          status;
  } entry_t;

  typedef struct packed {
    logic              listen;
    logic [CNT_W-1:0]  long_frames;
    logic [MASK_W-1:0] repeat_mask;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic             clicked;
    logic             pressed;
    logic             repeat_fire;
    logic             released;
    logic [CNT_W-1:0] held_frames;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/kpc_if.sv
// kpc_if: valid/ready channels for key items and classification results
// depends on kpc_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface kpc_in_if
  import kpc_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  key_index;
  logic              level;

  modport source (output valid, output kind, output key_index, output level, input ready);
  modport sink   (input valid, input kind, input key_index, input level, output ready);
endinterface

interface kpc_out_if
  import kpc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_echo;
  logic [2:0]       status_code;
  logic             clicked;
  logic             pressed;
  logic             repeat_fire;
  logic             released;
  logic [CNT_W-1:0] held_frames;

  modport source (output valid, output key_echo, output status_code, output clicked,
                  output pressed, output repeat_fire, output released,
                  output held_frames, input ready);
  modport sink   (input valid, input key_echo, input status_code, input clicked,
                  input pressed, input repeat_fire, input released,
                  input held_frames, output ready);
endinterface

`default_nettype wire

>>> hdl/kpc_ram.sv
// kpc_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module kpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a read of the entry being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/kpc_update.sv
// kpc_update: per-item entry update and status decode
// depends on kpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module kpc_update
  import kpc_pkg::*;
(
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic              level,
  input  wire logic              in_range,
  input  wire entry_t            cur,
  input  wire cfg_t              cfg,
  output entry_t                 nxt,
  output res_t                   res
);

  logic [CNT_W-1:0] cnt;
  status_t          st_adv;
  logic             cnt_nz;
  logic             mask_hit;

  always_comb begin
    cnt = cur.hold_count;
    if (cfg.listen) begin
      if (level) begin
        cnt = (cur.hold_count == CNT_MAX) ? CNT_MAX : cur.hold_count + CNT_W'(1);
      end else begin
        cnt = '0;
      end
    end
  end

  assign cnt_nz   = |cnt;
  assign mask_hit = ((cnt[MASK_W-1:0] & cfg.repeat_mask) == cfg.repeat_mask);

  always_comb begin
    case (cur.status)
      ST_CLICK:    st_adv = cnt_nz ? ST_SHORT : ST_RELEASED;
      ST_SHORT: begin
        if (!cnt_nz) st_adv = ST_RELEASED;
        else         st_adv = (cnt >= cfg.long_frames) ? ST_LONG : ST_SHORT;
      end
      ST_LONG, ST_REPEAT: begin
        if (!cnt_nz) st_adv = ST_RELEASED;
        else         st_adv = mask_hit ? ST_REPEAT : ST_LONG;
      end
      ST_BLOCKED:  st_adv = cnt_nz ? ST_BLOCKED : ST_IDLE;
      ST_RELEASED: st_adv = cnt_nz ? ST_CLICK : ST_IDLE;
      default:     st_adv = cnt_nz ? ST_CLICK : ST_IDLE;
    endcase
  end

  always_comb begin
    nxt = cur;
    case (kind)
      KIND_FRAME: begin
        nxt.hold_count = cnt;
        nxt.status     = st_adv;
      end
      KIND_BLOCK: nxt.status = ST_BLOCKED;
      default:    nxt = cur;
    endcase
  end

  always_comb begin
    res = '0;
    if (in_range) begin
      res.status      = nxt.status;
      res.held_frames = nxt.hold_count;
      res.clicked     = (nxt.status == ST_CLICK);
      res.pressed     = (nxt.status != ST_IDLE) && (nxt.status != ST_BLOCKED) &&
                        (nxt.status != ST_RELEASED);
      res.repeat_fire = (nxt.status == ST_CLICK) || (nxt.status == ST_REPEAT);
      res.released    = (nxt.status == ST_RELEASED);
    end
  end

endmodule

`default_nettype wire

>>> hdl/key_press_classifier.sv
// key_press_classifier: top level of the per-key press/hold/repeat classifier
// depends on kpc_pkg, kpc_if, kpc_ram and kpc_update
`timescale 1ns / 1ps
`default_nettype none

// usage
//   in_ch  : one transfer per item (kind, key_index, level); frame items
//            update the key, block items force it blocked, queries only look
//   out_ch : exactly one result transfer per item, in item order
//   cfg_*  : plain register writes (listen enable, long press threshold,
//            repeat mask), to be done only while no item is in flight
// result path: an accepted item passes the read stage and then the result
//   register, which drives out_ch.valid
// throughput: one item per cycle while out_ch.ready is high, also for the
//   same key back to back; the per-key table is one ram with registered
//   read, read on the input transfer, written back as the item leaves the
//   read stage and forwarded to a directly following item for the same key
// reset: all keys read as idle with a zero count at once (one valid bit
//   per key), registers return to their defaults, no clearing pass
// stall: while out_ch.ready is low the result register holds and the
//   item behind it waits in the read stage; in_ch.ready drops only when
//   both are occupied
module key_press_classifier
  import kpc_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  kpc_in_if.sink                     in_ch,
  kpc_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [8:0] NK = 9'(NUM_KEYS);

  // configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.listen      <= LISTEN_DEF;
      cfg_r.long_frames <= LONG_FRAMES_DEF;
      cfg_r.repeat_mask <= REPEAT_MASK_DEF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LISTEN:      cfg_r.listen      <= cfg_wdata[0];
        CFG_LONG_FRAMES: cfg_r.long_frames <= cfg_wdata[CNT_W-1:0];
        CFG_REPEAT_MASK: cfg_r.repeat_mask <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // input transfer and address
  logic          in_acc;
  logic [8:0]    in_key_ext;
  logic          in_range;
  logic [AW-1:0] in_addr;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign in_key_ext = {2'b00, in_ch.key_index};
  assign in_range   = (in_key_ext < NK);
  assign in_addr    = AW'(in_key_ext);

  // read stage: waits for the ram word
  logic              s1_valid_r;
  logic [KIND_W-1:0] s1_kind_r;
  logic [KEY_W-1:0]  s1_key_r;
  logic              s1_level_r;
  logic              s1_inr_r;
  logic              s1_vld_r;   // entry written since reset
  logic              s1_fwd_r;   // take the word written at the read edge
  logic [AW-1:0]     s1_addr;
  logic              s1_adv;
  logic              s1_fwd_nxt;

  // output register
  logic             out_valid_r;
  logic [KEY_W-1:0] out_key_r;
  res_t             out_res_r;

  assign s1_addr    = AW'({2'b00, s1_key_r});
  assign s1_adv     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // the word written this edge is not seen by a read at the same edge
  assign s1_fwd_nxt = s1_adv && s1_inr_r && in_range && (s1_addr == in_addr);

  // per-key valid bits and the last written word
  logic [NUM_KEYS-1:0] valid_r;
  entry_t              wb_entry_r;
  logic                mem_we;
  entry_t              upd_nxt;
  res_t                upd_res;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t              cur_entry;

  assign mem_we = s1_adv && s1_inr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
      valid_r    <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        s1_fwd_r   <= s1_fwd_nxt;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
        s1_fwd_r   <= 1'b0;
      end
      if (mem_we) begin
        valid_r[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r  <= in_ch.kind;
      s1_key_r   <= in_ch.key_index;
      s1_level_r <= in_ch.level;
      s1_inr_r   <= in_range;
      s1_vld_r   <= in_range && valid_r[in_addr];
    end
    if (mem_we) begin
      wb_entry_r <= upd_nxt;
    end
  end

  kpc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_KEYS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_addr),
    .wdata (upd_nxt),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // a never written entry reads as idle with a zero count
  always_comb begin
    if (s1_fwd_r)      cur_entry = wb_entry_r;
    else if (s1_vld_r) cur_entry = entry_t'(ram_rdata);
    else               cur_entry = '0;
  end

  kpc_update u_update (
    .kind     (s1_kind_r),
    .level    (s1_level_r),
    .in_range (s1_inr_r),
    .cur      (cur_entry),
    .cfg      (cfg_r),
    .nxt      (upd_nxt),
    .res      (upd_res)
  );

  // result register, refilled as it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_key_r <= s1_key_r;
      out_res_r <= upd_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.key_echo    = out_key_r;
  assign out_ch.status_code = out_res_r.status;
  assign out_ch.clicked     = out_res_r.clicked;
  assign out_ch.pressed     = out_res_r.pressed;
  assign out_ch.repeat_fire = out_res_r.repeat_fire;
  assign out_ch.released    = out_res_r.released;
  assign out_ch.held_frames = out_res_r.held_frames;

  // forwarding only ever applies to an in-range item in the read stage
  a_fwd_scope: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r |-> (s1_valid_r && s1_inr_r))
    else $error("forward flag outside an in-range read stage item");

  // a stalled read stage must not write the table again
  a_stall_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !mem_we)
    else $error("table written while result register stalled");

  // after a table write the key's valid bit is set
  a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> valid_r[$past(s1_addr)])
    else $error("valid bit not set after write");

  // results for keys beyond the table are all zero
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ({2'b00, out_key_r} >= NK)) |->
      (out_res_r.status == ST_IDLE && out_res_r.held_frames == '0))
    else $error("out-of-range key gave a non-zero result");

endmodule

`default_nettype wire

>>> tb/tb_key_press_classifier.sv
// tb_key_press_classifier: self-checking bench for the per-key press classifier
// needs kpc_pkg, kpc_if and key_press_classifier; predicts every result and
// checks it field by field against the out channel
`timescale 1ns / 1ps

module tb_key_press_classifier;
  import kpc_pkg::*;

  localparam int NUM_KEYS = NUM_KEYS_DEF;
  // kind code with no meaning of its own, behaves as a query
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  // quiet cycles before a register write and at the end
  localparam int SETTLE_CYCLES = 4;
  // cycles without any transfer before the watchdog gives up
  localparam int QUIET_LIMIT   = 500;
  localparam int MAX_PRINTED   = 40;

  // idling styles for the sender gaps and the receiver stalls
  typedef enum int {
    PACE_FLAT,
    PACE_RANDOM,
    PACE_SPARSE
  } pace_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic              level;
    int unsigned       gap;
  } key_item_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    status_t          st;
    logic             clicked;
    logic             pressed;
    logic             repeat_fire;
    logic             released;
    logic [CNT_W-1:0] held;
  } key_flags_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  kpc_in_if  in_ch ();
  kpc_out_if out_ch ();

  key_press_classifier #(.NUM_KEYS(NUM_KEYS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the key table and of the registers
  logic [CNT_W-1:0]  held_shadow [NUM_KEYS];
  status_t           status_shadow [NUM_KEYS];
  logic              listen_on;
  logic [CNT_W-1:0]  long_frames;
  logic [MASK_W-1:0] rep_mask;

  key_item_t   item_q [$];      // items waiting for the driver
  key_flags_t  flags_q [$];     // predicted results, oldest first
  key_item_t   cur_item;        // item on the in channel
  key_item_t   next_item;       // item waiting out its gap
  bit          staged;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  pace_t       tx_style;
  pace_t       rx_style;

  // traffic generator state: a few keys being pressed and held at once
  logic [KEY_W-1:0] active_keys [4];
  int unsigned      hold_plan [4];

  int unsigned err_count;
  int unsigned n_frames, n_blocks, n_queries;
  int unsigned n_checked, n_long_seen, n_saturated;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one status step from the counter after its update
  function automatic status_t next_status(status_t st, logic [CNT_W-1:0] c);
    status_t nxt;
    case (st)
      ST_CLICK: begin
        nxt = (c != '0) ? ST_SHORT : ST_RELEASED;
      end
      ST_SHORT: begin
        if (c == '0) nxt = ST_RELEASED;
        else if (c >= long_frames) nxt = ST_LONG;
        else nxt = ST_SHORT;
      end
      ST_LONG, ST_REPEAT: begin
        if (c == '0) nxt = ST_RELEASED;
        else if ((c & CNT_W'(rep_mask)) == CNT_W'(rep_mask)) nxt = ST_REPEAT;
        else nxt = ST_LONG;
      end
      ST_BLOCKED: begin
        nxt = (c != '0) ? ST_BLOCKED : ST_IDLE;
      end
      // idle, released and the unused code all start a fresh press
      default: begin
        nxt = (c != '0) ? ST_CLICK : ST_IDLE;
      end
    endcase
    return nxt;
  endfunction

  // applies one item to the shadow table and returns the key's flags
  function automatic key_flags_t classify_item(key_item_t it);
    key_flags_t       r;
    logic [CNT_W-1:0] c;
    status_t          st;
    c  = '0;
    st = ST_IDLE;
    if (int'(it.key) < NUM_KEYS) begin
      c  = held_shadow[it.key];
      st = status_shadow[it.key];
      if (it.kind == KIND_FRAME) begin
        // frozen counter while listening is off
        if (listen_on) c = it.level ? ((c == CNT_MAX) ? c : c + CNT_W'(1)) : '0;
        st = next_status(st, c);
      end else if (it.kind == KIND_BLOCK) begin
        st = ST_BLOCKED;
      end
      held_shadow[it.key]   = c;
      status_shadow[it.key] = st;
    end
    r.key         = it.key;
    r.st          = st;
    r.clicked     = (st == ST_CLICK);
    r.pressed     = (st != ST_IDLE) && (st != ST_BLOCKED) && (st != ST_RELEASED);
    r.repeat_fire = (st == ST_CLICK) || (st == ST_REPEAT);
    r.released    = (st == ST_RELEASED);
    r.held        = c;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------

  function automatic int unsigned draw_wait(pace_t style);
    case (style)
      PACE_FLAT:   return 0;
      PACE_RANDOM: return $urandom_range(0, 15);
      default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    endcase
  endfunction

  // length of the next press: mostly short taps, some long holds
  function automatic int unsigned draw_hold();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 0;
    else if (r < 60) return $urandom_range(1, 4);
    else if (r < 90) return $urandom_range(5, 30);
    else return $urandom_range(31, 300);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_count < MAX_PRINTED)
      $display("%0t mismatch on %s: got %0h, expected %0h (result %0d)",
               $realtime, what, got, want, n_checked);
    err_count++;
  endtask

  task automatic push_item(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key, logic level);
    key_item_t it;
    it.kind  = kind;
    it.key   = key;
    it.level = level;
    it.gap   = draw_wait(tx_style);
    item_q   = {item_q, it};
  endtask

  // sender holds off until every predicted result has come back
  task automatic wait_for_drain();
    do @(negedge clk);
    while (item_q.size() != 0 || staged || in_ch.valid || flags_q.size() != 0);
  endtask

  // registers are only written with the block empty
  task automatic set_config(logic listen, logic [CNT_W-1:0] frames,
                            logic [MASK_W-1:0] mask);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LISTEN;
    cfg_wdata <= CFG_DATA_W'(listen);
    @(posedge clk);
    cfg_index <= CFG_LONG_FRAMES;
    cfg_wdata <= CFG_DATA_W'(frames);
    @(posedge clk);
    cfg_index <= CFG_REPEAT_MASK;
    cfg_wdata <= CFG_DATA_W'(mask);
    @(posedge clk);
    cfg_we    <= 1'b0;
    listen_on   = listen;
    long_frames = frames;
    rep_mask    = mask;
  endtask

  // mostly well-formed press/hold/release runs on a few keys at a time,
  // the rest blocks, queries and stray frames on any key
  task automatic gen_traffic(int n);
    int unsigned j;
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        if (i != 0 && $urandom_range(0, 4) == 0) wait_for_drain();
        tx_style = pace_t'($urandom_range(0, 2));
        rx_style = pace_t'($urandom_range(0, 2));
        @(negedge clk);
      end
      while (item_q.size() >= 16) @(negedge clk);
      j = $urandom_range(0, 3);
      if ($urandom_range(0, 99) < 3) begin
        active_keys[j] = KEY_W'($urandom_range(0, NUM_KEYS - 1));
        hold_plan[j]   = 0;
      end
      r = $urandom_range(0, 99);
      if (r < 82) begin
        if (hold_plan[j] != 0) begin
          push_item(KIND_FRAME, active_keys[j], 1'b1);
          hold_plan[j]--;
        end else begin
          push_item(KIND_FRAME, active_keys[j], 1'b0);
          hold_plan[j] = draw_hold();
        end
      end else if (r < 88) begin
        push_item(KIND_BLOCK, $urandom_range(0, 1) ? active_keys[j] : KEY_W'($urandom()),
                  1'($urandom()));
      end else if (r < 94) begin
        push_item($urandom_range(0, 1) ? KIND_QUERY : KIND_SPARE, KEY_W'($urandom()),
                  1'($urandom()));
      end else begin
        push_item(KIND_FRAME, KEY_W'($urandom()), 1'($urandom()));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // driver: presents queued items after their gap, predicts on each transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      staged   = 1'b0;
      gap_left = 0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        held_shadow[i]   = '0;
        status_shadow[i] = ST_IDLE;
      end
    end else begin
      // input transfer: the key table moves on by one item
      if (in_ch.valid && in_ch.ready) begin
        flags_q = {flags_q, classify_item(cur_item)};
        if (cur_item.kind == KIND_FRAME) n_frames++;
        else if (cur_item.kind == KIND_BLOCK) n_blocks++;
        else n_queries++;
      end
      // slot free at this edge: stage the next item, then wait out its gap
      if (!in_ch.valid || in_ch.ready) begin
        if (!staged && item_q.size() != 0) begin
          next_item = item_q.pop_front();
          gap_left  = next_item.gap;
          staged    = 1'b1;
        end
        if (staged && gap_left == 0) begin
          in_ch.valid     <= 1'b1;
          in_ch.kind      <= next_item.kind;
          in_ch.key_index <= next_item.key;
          in_ch.level     <= next_item.level;
          cur_item = next_item;
          staged   = 1'b0;
        end else begin
          in_ch.valid <= 1'b0;
          if (staged) gap_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: stalls the result channel and checks each result transfer
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    key_flags_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (flags_q.size() == 0) begin
          report_mismatch("result with nothing predicted, key_echo",
                          32'(out_ch.key_echo), 'x);
        end else begin
          want = flags_q.pop_front();
          if (out_ch.key_echo !== want.key)
            report_mismatch("key_echo", 32'(out_ch.key_echo), 32'(want.key));
          if (out_ch.status_code !== want.st)
            report_mismatch("status_code", 32'(out_ch.status_code), 32'(want.st));
          if (out_ch.clicked !== want.clicked)
            report_mismatch("clicked", 32'(out_ch.clicked), 32'(want.clicked));
          if (out_ch.pressed !== want.pressed)
            report_mismatch("pressed", 32'(out_ch.pressed), 32'(want.pressed));
          if (out_ch.repeat_fire !== want.repeat_fire)
            report_mismatch("repeat_fire", 32'(out_ch.repeat_fire),
                            32'(want.repeat_fire));
          if (out_ch.released !== want.released)
            report_mismatch("released", 32'(out_ch.released), 32'(want.released));
          if (out_ch.held_frames !== want.held)
            report_mismatch("held_frames", 32'(out_ch.held_frames), 32'(want.held));
          if (want.st == ST_LONG || want.st == ST_REPEAT) n_long_seen++;
          if (want.held == CNT_MAX) n_saturated++;
        end
        n_checked++;
        stall_left = draw_wait(rx_style);
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no transfer on either channel for too long
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, flags_q.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_LISTEN;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_FRAME;
    in_ch.key_index = '0;
    in_ch.level     = 1'b0;
    out_ch.ready    = 1'b0;
    listen_on       = LISTEN_DEF;
    long_frames     = LONG_FRAMES_DEF;
    rep_mask        = REPEAT_MASK_DEF;
    tx_style        = PACE_RANDOM;
    rx_style        = PACE_RANDOM;
    err_count       = 0;
    n_frames        = 0;
    n_blocks        = 0;
    n_queries       = 0;
    n_checked       = 0;
    n_long_seen     = 0;
    n_saturated     = 0;
    for (int i = 0; i < 4; i++) begin
      active_keys[i] = KEY_W'($urandom_range(0, NUM_KEYS - 1));
      hold_plan[i]   = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: low threshold and odd mask so a short sequence gets far
    set_config(1'b1, 16'd3, 8'h01);
    @(negedge clk);
    // top key: click, short hold, long hold, long again, repeat, release, idle
    repeat (5) push_item(KIND_FRAME, 7'd127, 1'b1);
    repeat (2) push_item(KIND_FRAME, 7'd127, 1'b0);
    // key zero: queries change nothing, the spare kind neither, level ignored;
    // a blocked key stays blocked while held and goes idle once let go
    push_item(KIND_QUERY, 7'd0, 1'b1);
    push_item(KIND_SPARE, 7'd0, 1'b1);
    push_item(KIND_BLOCK, 7'd0, 1'b0);
    push_item(KIND_FRAME, 7'd0, 1'b1);
    push_item(KIND_BLOCK, 7'd0, 1'b1);
    push_item(KIND_FRAME, 7'd0, 1'b0);
    // alternating bits: click, release, click again from released, blocked mid-press
    push_item(KIND_FRAME, 7'd85, 1'b1);
    push_item(KIND_FRAME, 7'd85, 1'b0);
    push_item(KIND_FRAME, 7'd85, 1'b1);
    push_item(KIND_QUERY, 7'd85, 1'b0);
    push_item(KIND_BLOCK, 7'd85, 1'b0);
    push_item(KIND_FRAME, 7'd85, 1'b0);
    // idle key seen up stays idle
    push_item(KIND_FRAME, 7'd42, 1'b0);

    // random phases over several register settings
    set_config(LISTEN_DEF, LONG_FRAMES_DEF, REPEAT_MASK_DEF);
    gen_traffic(400);
    // zero mask: every long-hold frame is a repeat pulse
    set_config(1'b1, 16'd1, 8'h00);
    gen_traffic(300);
    // zero threshold: a held short hold turns long at once
    set_config(1'b1, 16'd0, 8'hFF);
    gen_traffic(300);
    // listening off: counters frozen, status still steps
    set_config(1'b0, CNT_W'($urandom_range(1, 20)), MASK_W'($urandom()));
    gen_traffic(250);
    set_config(1'b1, CNT_MAX, MASK_W'($urandom()));
    gen_traffic(200);
    set_config(1'b1, CNT_W'($urandom_range(2, 40)), MASK_W'($urandom()));
    gen_traffic(400);

    wait_for_drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d frame, %0d block and %0d query transfers, %0d results checked",
             n_frames, n_blocks, n_queries, n_checked);
    $display("%0d results in long hold or repeat, %0d at a saturated count, %0d mismatches",
             n_long_seen, n_saturated, err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
